### design/prime_factorizer_core_assert.svh
// ----------------------------------------------------------------------------
// prime_factorizer_core_assert.svh
// Assertion macros for the prime factorizer; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIME_FACTORIZER_CORE_ASSERT_SVH
`define PRIME_FACTORIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked out of reset.
`define PF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`else

`define PF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### design/pfac_pkg.sv
// ----------------------------------------------------------------------------
// pfac_pkg
// Shared widths, types and state encoding of the prime factorizer.
// ----------------------------------------------------------------------------
package pfac_pkg;

    // Number of low input bits that are factored.
    localparam int VALUE_WIDTH = 32;

    // Datapath width: the input field is 32 bits, so wider settings change nothing.
    localparam int DW      = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    // Width of the running divisor square.
    localparam int SW      = DW + 2;
    localparam int PRIME_W = 32;
    localparam int EXP_W   = 5;
    localparam int CNT_W   = $clog2(DW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [DW-1:0]    prime;
        logic [EXP_W-1:0] exponent;
        logic             no_factors;
        logic             last;
    } res_t;

endpackage

### design/prime_factorizer_core.sv
// ----------------------------------------------------------------------------
// prime_factorizer_core
// Trial-division prime factorizer with streaming input and result channels.
// ----------------------------------------------------------------------------
// Usage: one item on the s_axis channel carries an unsigned value to factor.
// The block answers with one result item per distinct prime on m_axis, in
// ascending order of prime, each carrying the prime and its exponent; tlast
// marks the final result of the value. Values 0 and 1 give a single result
// with prime 0, exponent 0 and the no_factors flag in tuser set.
// A value of 0 or 1 goes from idle straight to the emit state, which hands
// its result to the output register. Otherwise divisors 2, 3, 5, 7 and on
// through the odd numbers are tried up to the square root of what is left;
// each trial is one run of the bit-serial divider, which produces one
// quotient bit per cycle, and each exact division that takes a factor out
// costs another run. A large prime input therefore takes about 32768
// trials. s_axis_tready is high only between values. Results pass through
// an output register, so a new value can be accepted while the final
// result of the last one is still waiting. If the receiver stalls, the
// sequencer holds at its next result until the output register frees up;
// nothing is dropped. Reset (aresetn low, sampled on the clock) returns the
// sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
`include "prime_factorizer_core_assert.svh"

module prime_factorizer_core
    import pfac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] prime, [36:32] exponent, [39:37] zero
    output logic [0:0]  m_axis_tuser,   // [0] no_factors
    output logic        m_axis_tlast
);

    res_t     res;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     slot_free;

    logic               m_valid_reg, m_valid_next;
    logic [PRIME_W-1:0] m_prime_reg, m_prime_next;
    logic [EXP_W-1:0]   m_exp_reg, m_exp_next;
    logic               m_none_reg, m_none_next;
    logic               m_last_reg, m_last_next;

    // The output register can take a new result when empty or being drained.
    assign slot_free = !m_valid_reg || m_axis_tready;

    pfac_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_value  (s_axis_tdata[DW-1:0]),
        .in_ready  (s_axis_tready),
        .slot_free (slot_free),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    pfac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        m_exp_next   = m_exp_reg;
        m_none_next  = m_none_reg;
        m_last_next  = m_last_reg;
        if (res.valid && slot_free) begin
            m_valid_next = 1'b1;
            m_prime_next = PRIME_W'(res.prime);
            m_exp_next   = res.exponent;
            m_none_next  = res.no_factors;
            m_last_next  = res.last;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_prime_reg <= m_prime_next;
        m_exp_reg   <= m_exp_next;
        m_none_reg  <= m_none_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_exp_reg, m_prime_reg};
    assign m_axis_tuser  = m_none_reg;
    assign m_axis_tlast  = m_last_reg;

    // A value with no factors gives exactly one result, empty and final.
    `PF_ASSERT_IMPL(a_none_form, aclk, aresetn,
        m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast && (m_axis_tdata[36:0] == 37'd0))

    // A real factor is at least two and has a nonzero exponent.
    `PF_ASSERT_IMPL(a_factor_form, aclk, aresetn,
        m_axis_tvalid && !m_axis_tuser[0],
        (m_axis_tdata[31:0] >= 32'd2) && (m_axis_tdata[36:32] != 5'd0))

    // Once a value is taken, the block is busy with it in the next cycle.
    `PF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

### design/pfac_div.sv
// ----------------------------------------------------------------------------
// pfac_div
// Restoring divider, one quotient bit per cycle, shared by all trial divisions.
// ----------------------------------------------------------------------------
module pfac_div
    import pfac_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [DW:0]      trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### design/pfac_ctrl.sv
// ----------------------------------------------------------------------------
// pfac_ctrl
// Sequencer that walks trial divisors and drives the shared divider.
// ----------------------------------------------------------------------------
module pfac_ctrl
    import pfac_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [DW-1:0] in_value,
    output logic          in_ready,
    input  logic          slot_free,
    output res_t          res,
    output div_req_t      div_req,
    input  div_rsp_t      div_rsp
);

    state_t           state_reg, state_next;
    logic [DW-1:0]    rest_reg, rest_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [SW-1:0]    sq_reg, sq_next;
    logic [EXP_W-1:0] expo_reg, expo_next;
    logic [DW-1:0]    pp_reg, pp_next;
    logic [EXP_W-1:0] pe_reg, pe_next;
    logic             pn_reg, pn_next;
    logic             pl_reg, pl_next;

    logic             accept;
    logic             in_small;
    logic             sq_fits;
    logic             rest_big;
    logic             exact;
    logic [DW-1:0]    d_adv;
    logic [SW-1:0]    sq_adv;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_small = in_value < DW'(2);
    assign sq_fits  = sq_reg <= SW'(rest_reg);
    assign rest_big = rest_reg > DW'(1);
    assign exact    = div_rsp.rem == '0;

    // After two, only odd divisors are tried; (d+2)^2 = d^2 + 4d + 4.
    always_comb begin
        if (d_reg == DW'(2)) begin
            d_adv  = DW'(3);
            sq_adv = SW'(9);
        end else begin
            d_adv  = d_reg + DW'(2);
            sq_adv = sq_reg + {d_reg, 2'b00} + SW'(4);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = in_small ? ST_EMIT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sq_fits) begin
                    state_next = ST_DIV;
                end else if (rest_big) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_rsp.done && !exact) begin
                    state_next = (expo_reg != '0) ? ST_EMIT : ST_CHECK;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = pl_reg ? ST_IDLE : ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers and outputs.
    always_comb begin
        rest_next        = rest_reg;
        d_next           = d_reg;
        sq_next          = sq_reg;
        expo_next        = expo_reg;
        pp_next          = pp_reg;
        pe_next          = pe_reg;
        pn_next          = pn_reg;
        pl_next          = pl_reg;
        div_req.start    = 1'b0;
        div_req.dividend = rest_reg;
        div_req.divisor  = d_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rest_next = in_value;
                    d_next    = DW'(2);
                    sq_next   = SW'(4);
                    expo_next = '0;
                    pp_next   = '0;
                    pe_next   = '0;
                    pn_next   = 1'b1;
                    pl_next   = 1'b1;
                end
            end
            ST_CHECK: begin
                if (sq_fits) begin
                    div_req.start = 1'b1;
                end else begin
                    // What is left over is a prime above the square root.
                    pp_next = rest_reg;
                    pe_next = EXP_W'(1);
                    pn_next = 1'b0;
                    pl_next = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (exact) begin
                        rest_next        = div_rsp.quot;
                        expo_next        = expo_reg + EXP_W'(1);
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quot;
                    end else if (expo_reg != '0) begin
                        // A remainder above one always yields another result.
                        pp_next = d_reg;
                        pe_next = expo_reg;
                        pn_next = 1'b0;
                        pl_next = rest_reg == DW'(1);
                    end else begin
                        d_next  = d_adv;
                        sq_next = sq_adv;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free && !pl_reg) begin
                    d_next    = d_adv;
                    sq_next   = sq_adv;
                    expo_next = '0;
                end
            end
            default: begin
                rest_next = rest_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        rest_reg <= rest_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        expo_reg <= expo_next;
        pp_reg   <= pp_next;
        pe_reg   <= pe_next;
        pn_reg   <= pn_next;
        pl_reg   <= pl_next;
    end

    assign in_ready       = state_reg == ST_IDLE;
    assign res.valid      = state_reg == ST_EMIT;
    assign res.prime      = pp_reg;
    assign res.exponent   = pe_reg;
    assign res.no_factors = pn_reg;
    assign res.last       = pl_reg;

endmodule

### test/tb_prime_factorizer_core.sv
// ----------------------------------------------------------------------------
// tb_prime_factorizer_core
// Self-checking testbench for the trial-division prime factorizer. A local
// factorizer predicts every prime/exponent item. The result stream is checked
// item by item while both sides of the block idle at random.
// ----------------------------------------------------------------------------
module tb_prime_factorizer_core;
    import pfac_pkg::*;

    localparam int IDLE_LIMIT   = 50000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_FACTORS  = 9;

    typedef struct packed {
        logic [31:0] prime;
        logic [4:0]  exponent;
        logic        no_factors;
        logic        last;
    } factor_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    factor_t expected_factors[$];
    int      error_count  = 0;
    int      burst_left   = 0;
    bit      gaps_enabled = 1'b1;
    int      hold_request = 0;
    int      hold_left    = 0;
    int      ready_mode   = 0;
    int      mode_left    = 0;

    prime_factorizer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("mismatch: %s", msg);
        end
        error_count++;
    endtask

    // Factors one value and queues the items the block should produce for it.
    task automatic predict_factors(input logic [31:0] value);
        longint unsigned rest;
        longint unsigned div;
        int unsigned     expo;
        factor_t         group[$];
        factor_t         item;
        rest = value;
        if (DW < 32) begin
            rest = rest & ((64'd1 << DW) - 1);
        end
        if (rest < 2) begin
            item = '{prime: '0, exponent: '0, no_factors: 1'b1, last: 1'b1};
            expected_factors.push_back(item);
            return;
        end
        for (div = 2; div * div <= rest; div++) begin
            expo = 0;
            while (rest % div == 0) begin
                rest = rest / div;
                expo++;
            end
            if (expo > 0 && group.size() < MAX_FACTORS) begin
                item = '{prime: div[31:0], exponent: expo[4:0], no_factors: 1'b0, last: 1'b0};
                group.push_back(item);
            end
        end
        if (rest > 1 && group.size() < MAX_FACTORS) begin
            item = '{prime: rest[31:0], exponent: 5'd1, no_factors: 1'b0, last: 1'b0};
            group.push_back(item);
        end
        group[group.size() - 1].last = 1'b1;
        foreach (group[i]) begin
            expected_factors.push_back(group[i]);
        end
    endtask

    // Offers one value, waits for it to be taken, then maybe pauses between bursts.
    task automatic send_value(input logic [31:0] value);
        int gap;
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        predict_factors(value);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_enabled) begin
            burst_left = $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Product of small factors times a modest cofactor, so trial division stays short.
    function automatic logic [31:0] smooth_value();
        longint unsigned acc;
        longint unsigned fac;
        int              steps;
        acc   = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 16384);
        steps = $urandom_range(1, 32);
        for (int i = 0; i < steps; i++) begin
            fac = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 7) : $urandom_range(2, 97);
            if (acc * fac <= 64'hFFFF_FFFF) begin
                acc = acc * fac;
            end
        end
        return acc[31:0];
    endfunction

    task automatic test_no_factors();
        send_value(32'd0);
        send_value(32'd1);
    endtask

    task automatic test_prime_values();
        send_value(32'd2);
        send_value(32'd3);
        send_value(32'd251);
        send_value(32'd65537);
    endtask

    task automatic test_prime_powers();
        send_value(32'd4);
        send_value(32'd63001);         // 251 squared
        send_value(32'h8000_0000);     // two to the 31st, largest exponent
        send_value(32'd3486784401);    // three to the 20th
    endtask

    task automatic test_extreme_values();
        send_value(32'hFFFF_FFFF);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        send_value(32'd12);
    endtask

    task automatic test_many_primes();
        send_value(32'd223092870);     // first nine primes
        send_value(32'd446185740);
        send_value(32'd3869835264);
    endtask

    // The receiver holds off while values keep coming, so the block must stall its input.
    task automatic test_output_backpressure();
        gaps_enabled = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (6) send_value(32'd223092870);
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_values();
        int pick;
        repeat (77) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_value($urandom_range(0, 1));
            end else if (pick < 20) begin
                send_value($urandom_range(2, 5000));
            end else begin
                send_value(smooth_value());
            end
        end
    endtask

    // Result checker: every accepted item is compared with the oldest prediction.
    always @(posedge aclk) begin
        factor_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_factors.size() == 0) begin
                report_mismatch($sformatf("unexpected item prime %0d", m_axis_tdata[31:0]));
            end else begin
                want = expected_factors.pop_front();
                if (m_axis_tdata[31:0] !== want.prime) begin
                    report_mismatch($sformatf("prime got %0d expected %0d",
                                              m_axis_tdata[31:0], want.prime));
                end
                if (m_axis_tdata[36:32] !== want.exponent) begin
                    report_mismatch($sformatf("exponent got %0d expected %0d for prime %0d",
                                              m_axis_tdata[36:32], want.exponent, want.prime));
                end
                if (m_axis_tuser[0] !== want.no_factors) begin
                    report_mismatch($sformatf("no_factors got %b expected %b for prime %0d",
                                              m_axis_tuser[0], want.no_factors, want.prime));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last got %b expected %b for prime %0d",
                                              m_axis_tlast, want.last, want.prime));
                end
            end
        end
    end

    // Receiver: alternates between stretches of always ready, random and sparse ready.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_request > 0) begin
            m_axis_tready <= 1'b0;
            hold_left    = hold_request - 1;
            hold_request = 0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(10, 120);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (aresetn && ((s_axis_tvalid && s_axis_tready) ||
                            (m_axis_tvalid && m_axis_tready))) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_no_factors();
        test_prime_values();
        test_prime_powers();
        test_extreme_values();
        test_many_primes();
        test_output_backpressure();
        test_random_values();

        s_axis_tvalid <= 1'b0;
        while (expected_factors.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
